@@ rtl/mwms_pkg.sv @@
package mwms_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int RING_AW     = $clog2(MAX_WINDOW);
  localparam int WL_W        = 11;
  localparam int SUM_W       = 27;
  localparam int SQ_W        = 41;
  localparam int N_W         = 52;
  localparam int ACC_W       = 53;
  localparam int MUL_W       = 26;
  localparam int UNUM_W      = 76;
  localparam int UREM_W      = 54;
  localparam int CNT_W       = 7;
  localparam int ROOT_W      = 38;
  localparam int DIV_STEPS   = 76;
  localparam int SQRT_STEPS  = 38;
  localparam int WL_RESET    = 64;
  localparam int WL_MIN      = 2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQN, ST_SQO, ST_ADJ, ST_WLO, ST_WHI, ST_SS, ST_N,
    ST_MEAN, ST_SQRT, ST_STD, ST_IDIV, ST_ISQRT, ST_LOAD
  } state_t;

  typedef enum logic {UOP_DIV, UOP_SQRT} uop_t;

  typedef struct packed {
    logic start;
    uop_t op;
  } ucmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ustat_t;

endpackage

@@ rtl/mwms_sqdiv.sv @@
module mwms_sqdiv (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mwms_pkg::ucmd_t                cmd,
  input  logic [mwms_pkg::UNUM_W-1:0]    num,
  input  logic [mwms_pkg::N_W-1:0]       den,
  output mwms_pkg::ustat_t               stat,
  output logic [mwms_pkg::UNUM_W-1:0]    res
);

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  mwms_pkg::uop_t                 op_r;
  logic [mwms_pkg::UNUM_W-1:0]    x_r;
  logic [mwms_pkg::N_W-1:0]       den_r;
  logic [mwms_pkg::UREM_W-1:0]    rem_r;
  logic [mwms_pkg::UNUM_W-1:0]    q_r;
  logic [mwms_pkg::CNT_W-1:0]     cnt_r;
  logic [mwms_pkg::UREM_W-1:0]    rem_sh, trial, rem_new;
  logic                           ge;

  always_comb begin
    if (op_r == mwms_pkg::UOP_SQRT) begin
      rem_sh = {rem_r[mwms_pkg::UREM_W-3:0], x_r[mwms_pkg::UNUM_W-1 -: 2]};
      trial  = {q_r[mwms_pkg::UREM_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem_r[mwms_pkg::UREM_W-2:0], x_r[mwms_pkg::UNUM_W-1]};
      trial  = {{(mwms_pkg::UREM_W-mwms_pkg::N_W){1'b0}}, den_r};
    end
    ge      = (rem_sh >= trial);
    rem_new = ge ? (rem_sh - trial) : rem_sh;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (!busy_r && cmd.start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && (cnt_r == mwms_pkg::CNT_W'(1))) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && cmd.start) begin
      op_r  <= cmd.op;
      x_r   <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= (cmd.op == mwms_pkg::UOP_SQRT) ? mwms_pkg::CNT_W'(mwms_pkg::SQRT_STEPS)
                                              : mwms_pkg::CNT_W'(mwms_pkg::DIV_STEPS);
    end else if (busy_r) begin
      x_r   <= (op_r == mwms_pkg::UOP_SQRT) ? {x_r[mwms_pkg::UNUM_W-3:0], 2'b00}
                                            : {x_r[mwms_pkg::UNUM_W-2:0], 1'b0};
      rem_r <= rem_new;
      q_r   <= {q_r[mwms_pkg::UNUM_W-2:0], ge};
      cnt_r <= cnt_r - mwms_pkg::CNT_W'(1);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign res       = q_r;

endmodule

@@ rtl/moving_window_mean_std_top.sv @@
// From an accepted word to its result: setup and multiplier states SQN, SQO, ADJ,
// WLO, WHI, SS and N, three divides and two roots on one shared shift-subtract
// unit, then a load state; at zero variance the last divide and root are skipped.
// A word that leaves the window not yet full passes only SQN, SQO and ADJ and gives
// no result. No new word is taken before the last is through; in_stall is high while
// a word is worked on, and the load state waits while a result is held by out_stall.
// Reset: synchronous active-low; clears the window, sets window_length to 64.
// Ring contents are undefined after reset and need no clearing pass.
module moving_window_mean_std_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mwms_pkg::WL_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mwms_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [25:0]                  out_window_sum,
  output logic [40:0]                         out_window_square_sum,
  output logic signed [23:0]                  out_window_mean,
  output logic [23:0]                         out_std_dev,
  output logic [36:0]                         out_inverse_norm,
  output logic                                out_zero_variance
);

  localparam int AW = mwms_pkg::RING_AW;
  localparam int SB = mwms_pkg::SAMPLE_BITS;

  mwms_pkg::state_t state_r, state_nxt;

  logic [mwms_pkg::WL_W-1:0]  wl_r, w_eff;
  logic signed [mwms_pkg::SUM_W-1:0] sum_r;
  logic [mwms_pkg::SQ_W-1:0]  ss_r;
  logic [AW-1:0]              wp_r, wp_eff, wp_adv;
  logic [mwms_pkg::WL_W-1:0]  fill_r;
  logic                       full_r, full_in, accept;
  logic signed [SB-1:0]       sample_r, old_r;
  logic [SB-1:0]              ring [mwms_pkg::MAX_WINDOW];
  logic [SB-1:0]              mag, om;
  logic [mwms_pkg::MUL_W-1:0] smag, mul_a, mul_b;
  logic [2*mwms_pkg::MUL_W-1:0] prod_r;
  logic [mwms_pkg::ACC_W-1:0] acc_r;
  logic [mwms_pkg::N_W-1:0]   n_r;
  logic                       zero_r;
  logic [23:0]                mean_mag_r, std_r;
  logic [mwms_pkg::ROOT_W-1:0] root_r;
  logic [mwms_pkg::UNUM_W-1:0] quot_r;
  logic [36:0]                inv_r;
  logic                       launched_r, out_valid_r, load;

  mwms_pkg::ucmd_t            ucmd;
  mwms_pkg::ustat_t           ustat;
  logic [mwms_pkg::UNUM_W-1:0] unum, ures;
  logic [mwms_pkg::N_W-1:0]   uden;
  logic                       ustate;

  always_comb begin
    if (wl_r < mwms_pkg::WL_W'(mwms_pkg::WL_MIN)) begin
      w_eff = mwms_pkg::WL_W'(mwms_pkg::WL_MIN);
    end else if (wl_r > mwms_pkg::WL_W'(mwms_pkg::MAX_WINDOW)) begin
      w_eff = mwms_pkg::WL_W'(mwms_pkg::MAX_WINDOW);
    end else begin
      w_eff = wl_r;
    end
  end

  assign accept  = (state_r == mwms_pkg::ST_IDLE) && in_valid;
  assign full_in = !in_restart && (fill_r >= w_eff);
  assign wp_eff  = (in_restart || ({1'b0, wp_r} >= w_eff)) ? '0 : wp_r;
  assign wp_adv  = (({1'b0, wp_r} + mwms_pkg::WL_W'(1)) == w_eff) ? '0 : wp_r + AW'(1);
  assign mag     = sample_r[SB-1] ? SB'(-sample_r) : SB'(sample_r);
  assign om      = old_r[SB-1] ? SB'(-old_r) : SB'(old_r);
  assign smag    = sum_r[mwms_pkg::SUM_W-1] ? mwms_pkg::MUL_W'(-sum_r)
                                            : mwms_pkg::MUL_W'(sum_r);

  // ring
  always_ff @(posedge clk) begin
    if (accept) begin
      old_r <= ring[wp_eff];
    end
    if (state_r == mwms_pkg::ST_SQO) begin
      ring[wp_r] <= sample_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mwms_pkg::ST_IDLE:  if (in_valid) state_nxt = mwms_pkg::ST_SQN;
      mwms_pkg::ST_SQN:   state_nxt = mwms_pkg::ST_SQO;
      mwms_pkg::ST_SQO:   state_nxt = mwms_pkg::ST_ADJ;
      mwms_pkg::ST_ADJ:   state_nxt = (fill_r < w_eff) ? mwms_pkg::ST_IDLE : mwms_pkg::ST_WLO;
      mwms_pkg::ST_WLO:   state_nxt = mwms_pkg::ST_WHI;
      mwms_pkg::ST_WHI:   state_nxt = mwms_pkg::ST_SS;
      mwms_pkg::ST_SS:    state_nxt = mwms_pkg::ST_N;
      mwms_pkg::ST_N:     state_nxt = mwms_pkg::ST_MEAN;
      mwms_pkg::ST_MEAN:  if (ustat.done) state_nxt = mwms_pkg::ST_SQRT;
      mwms_pkg::ST_SQRT:  if (ustat.done) state_nxt = mwms_pkg::ST_STD;
      mwms_pkg::ST_STD:   if (ustat.done) state_nxt = zero_r ? mwms_pkg::ST_LOAD
                                                               : mwms_pkg::ST_IDIV;
      mwms_pkg::ST_IDIV:  if (ustat.done) state_nxt = mwms_pkg::ST_ISQRT;
      mwms_pkg::ST_ISQRT: if (ustat.done) state_nxt = mwms_pkg::ST_LOAD;
      mwms_pkg::ST_LOAD:  if (!out_valid_r || !out_stall) state_nxt = mwms_pkg::ST_IDLE;
      default:            state_nxt = mwms_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = (state_r != mwms_pkg::ST_IDLE);
    load     = (state_r == mwms_pkg::ST_LOAD) && (!out_valid_r || !out_stall);
    ustate   = 1'b0;
    ucmd.op  = mwms_pkg::UOP_DIV;
    unum     = '0;
    uden     = mwms_pkg::N_W'(w_eff);
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      mwms_pkg::ST_SQN: begin
        mul_a = mwms_pkg::MUL_W'(mag);
        mul_b = mwms_pkg::MUL_W'(mag);
      end
      mwms_pkg::ST_SQO: begin
        mul_a = mwms_pkg::MUL_W'(om);
        mul_b = mwms_pkg::MUL_W'(om);
      end
      mwms_pkg::ST_WLO: begin
        mul_a = mwms_pkg::MUL_W'(w_eff);
        mul_b = mwms_pkg::MUL_W'(ss_r[20:0]);
      end
      mwms_pkg::ST_WHI: begin
        mul_a = mwms_pkg::MUL_W'(w_eff);
        mul_b = mwms_pkg::MUL_W'(ss_r[40:21]);
      end
      mwms_pkg::ST_SS: begin
        mul_a = smag;
        mul_b = smag;
      end
      mwms_pkg::ST_MEAN: begin
        ustate = 1'b1;
        unum   = mwms_pkg::UNUM_W'({smag, 8'b0});
      end
      mwms_pkg::ST_SQRT: begin
        ustate  = 1'b1;
        ucmd.op = mwms_pkg::UOP_SQRT;
        unum    = mwms_pkg::UNUM_W'({n_r, 16'b0});
      end
      mwms_pkg::ST_STD: begin
        ustate = 1'b1;
        unum   = mwms_pkg::UNUM_W'(root_r);
      end
      mwms_pkg::ST_IDIV: begin
        ustate = 1'b1;
        unum   = {w_eff, 64'b0, 1'b0} >> 1;
        uden   = n_r;
      end
      mwms_pkg::ST_ISQRT: begin
        ustate  = 1'b1;
        ucmd.op = mwms_pkg::UOP_SQRT;
        unum    = quot_r;
      end
      default: ;
    endcase
    ucmd.start = ustate && !launched_r && !ustat.busy;
  end

  mwms_sqdiv u_sqdiv (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (ucmd),
    .num  (unum),
    .den  (uden),
    .stat (ustat),
    .res  (ures)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mwms_pkg::ST_IDLE;
      wl_r        <= mwms_pkg::WL_W'(mwms_pkg::WL_RESET);
      sum_r       <= '0;
      ss_r        <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ucmd.start) begin
        launched_r <= 1'b1;
      end else if (ustat.done) begin
        launched_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        wl_r   <= cfg_wdata;
        sum_r  <= '0;
        ss_r   <= '0;
        wp_r   <= '0;
        fill_r <= '0;
      end else begin
        unique case (state_r)
          mwms_pkg::ST_IDLE: if (in_valid) begin
            if (in_restart) begin
              sum_r  <= '0;
              ss_r   <= '0;
              fill_r <= '0;
            end
            wp_r <= wp_eff;
          end
          mwms_pkg::ST_SQO: begin
            ss_r  <= ss_r + mwms_pkg::SQ_W'(prod_r);
            sum_r <= sum_r + mwms_pkg::SUM_W'(sample_r)
                     - (full_r ? mwms_pkg::SUM_W'(old_r) : '0);
            wp_r  <= wp_adv;
            if (!full_r) fill_r <= fill_r + mwms_pkg::WL_W'(1);
          end
          mwms_pkg::ST_ADJ: if (full_r) ss_r <= ss_r - mwms_pkg::SQ_W'(prod_r);
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      full_r   <= full_in;
    end
    prod_r <= mul_a * mul_b;
    if (state_r == mwms_pkg::ST_WHI) acc_r <= mwms_pkg::ACC_W'(prod_r);
    if (state_r == mwms_pkg::ST_SS)  acc_r <= acc_r + mwms_pkg::ACC_W'({prod_r, 21'b0});
    if (state_r == mwms_pkg::ST_N) begin
      n_r    <= mwms_pkg::N_W'(acc_r - mwms_pkg::ACC_W'(prod_r));
      zero_r <= (acc_r == mwms_pkg::ACC_W'(prod_r));
      inv_r  <= '1;
    end
    if (ustat.done) begin
      unique case (state_r)
        mwms_pkg::ST_MEAN:  mean_mag_r <= ures[23:0];
        mwms_pkg::ST_SQRT:  root_r     <= ures[mwms_pkg::ROOT_W-1:0];
        mwms_pkg::ST_STD:   std_r      <= ures[23:0];
        mwms_pkg::ST_IDIV:  quot_r     <= ures;
        mwms_pkg::ST_ISQRT: inv_r      <= ures[37] ? '1 : ures[36:0];
        default: ;
      endcase
    end
    if (load) begin
      out_window_sum        <= sum_r[25:0];
      out_window_square_sum <= ss_r;
      out_window_mean       <= sum_r[mwms_pkg::SUM_W-1] ? -mean_mag_r : mean_mag_r;
      out_std_dev           <= std_r;
      out_inverse_norm      <= inv_r;
      out_zero_variance     <= zero_r;
    end
  end

  assign out_valid = out_valid_r;

  a_fill_le_w: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_eff)
    else $error("fill count above window length");
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_variance |-> (out_inverse_norm == '1) && (out_std_dev == '0))
    else $error("zero variance result not saturated");
  a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ustat.busy |-> ustate)
    else $error("shared unit busy outside a unit state");
  a_one_launch: assert property (@(posedge clk) disable iff (!rst_n)
    ucmd.start |=> !ucmd.start)
    else $error("shared unit started twice");

endmodule
